FILE: rtl/rti_pkg.sv
//------------------------------------------------------------------------------
// rti_pkg
// Shared types, constants and single-precision helper functions for the
// ray/triangle intersection pipeline.
//------------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

   typedef logic [31:0] float_type;

   typedef struct packed {
      logic sign;
      logic nan;
      logic inf;
      logic zero;
   } fp_class_type;

   typedef struct packed {
      logic                sign;
      logic                nan;
      logic                inf;
      logic                zero;
      logic signed [10:0]  exp;
      logic [23:0]         man;
   } fp_unpacked_type;

   typedef enum logic [2:0] {
      CSR_A_XY = 3'd0,
      CSR_A_Z  = 3'd1,
      CSR_B_XY = 3'd2,
      CSR_B_Z  = 3'd3,
      CSR_C_XY = 3'd4,
      CSR_C_Z  = 3'd5
   } csr_index_type;

   localparam float_type NEAR_PARALLEL = 32'h358637BD;
   localparam float_type QNAN          = 32'h7FC00000;

   localparam int MUL_LAT  = 3;
   localparam int ADD_LAT  = 3;
   localparam int QUO_BITS = 26;
   localparam int DIV_LAT  = QUO_BITS + 2;

   function automatic logic [4:0] lzc28(input logic [27:0] x);
      logic [4:0] n;
      logic       found;
      n     = 5'd0;
      found = 1'b0;
      for (int i = 27; i >= 0; i--) begin
         if (!found) begin
            if (x[i]) begin
               found = 1'b1;
            end else begin
               n = n + 5'd1;
            end
         end
      end
      return n;
   endfunction

   function automatic logic fp_is_nan(input float_type x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic fp_unpacked_type fp_unpack(input float_type x, input logic norm);
      fp_unpacked_type u;
      logic [4:0]      lz;
      u.sign = x[31];
      u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
      u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
      u.zero = (x[30:23] == 8'h00) && (x[22:0] == 23'd0);
      if (x[30:23] == 8'h00) begin
         u.man = {1'b0, x[22:0]};
         u.exp = 11'sd1;
      end else begin
         u.man = {1'b1, x[22:0]};
         u.exp = $signed({3'b000, x[30:23]});
      end
      lz = lzc28({u.man, 4'hF});
      if (norm) begin
         u.man = u.man << lz;
         u.exp = u.exp - $signed({6'd0, lz});
      end
      return u;
   endfunction

   // sig holds 1.23 mantissa, guard, round and sticky; value = sig/2^26 * 2^(exp-127)
   function automatic float_type fp_round(input logic sign, input logic signed [10:0] exp,
                                          input logic [26:0] sig);
      logic [26:0]        s;
      logic signed [10:0] shv;
      logic [4:0]         sh;
      logic               denorm;
      logic               inc;
      logic [24:0]        m;
      logic signed [11:0] ef;
      logic [22:0]        frac;
      float_type          r;
      denorm = (exp < 11'sd1);
      shv    = 11'sd1 - exp;
      sh     = (shv > 11'sd27) ? 5'd27 : shv[4:0];
      s      = sig;
      if (denorm) begin
         s = (sig >> sh) | {26'd0, |(sig & ((27'd1 << sh) - 27'd1))};
      end
      inc = s[2] & (s[3] | s[1] | s[0]);
      m   = {1'b0, s[26:3]} + {24'd0, inc};
      if (denorm) begin
         ef   = $signed({11'd0, m[23]});
         frac = m[22:0];
      end else begin
         ef   = $signed({exp[10], exp}) + $signed({11'd0, m[24]});
         frac = m[24] ? m[23:1] : m[22:0];
      end
      if (ef > 12'sd254) begin
         r = {sign, 8'hFF, 23'd0};
      end else begin
         r = {sign, ef[7:0], frac};
      end
      return r;
   endfunction

   function automatic float_type fp_select(input fp_class_type c, input float_type r);
      float_type o;
      if (c.nan) begin
         o = QNAN;
      end else if (c.inf) begin
         o = {c.sign, 8'hFF, 23'd0};
      end else if (c.zero) begin
         o = {c.sign, 31'd0};
      end else begin
         o = r;
      end
      return o;
   endfunction

   function automatic logic [31:0] fp_key(input float_type x);
      logic [31:0] k;
      if (x[30:0] == 31'd0) begin
         k = 32'h80000000;
      end else if (x[31]) begin
         k = ~x;
      end else begin
         k = {1'b1, x[30:0]};
      end
      return k;
   endfunction

   function automatic logic fp_gt(input float_type a, input float_type b);
      return !fp_is_nan(a) && !fp_is_nan(b) && (fp_key(a) > fp_key(b));
   endfunction

   function automatic logic fp_lt0(input float_type a);
      return a[31] && (a[30:0] != 31'd0) && !fp_is_nan(a);
   endfunction

   function automatic logic fp_gt0(input float_type a);
      return !a[31] && (a[30:0] != 31'd0) && !fp_is_nan(a);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rti_fmul.sv
//------------------------------------------------------------------------------
// rti_fmul
// Three-stage single-precision multiplier, round to nearest even:
// unpack and normalize, mantissa product, normalize and round.
//------------------------------------------------------------------------------
`default_nettype none

module rti_fmul (
   input  wire                 clock,
   input  wire                 en,
   input  rti_pkg::float_type  a,
   input  rti_pkg::float_type  b,
   output rti_pkg::float_type  y
);
   import rti_pkg::*;

   fp_unpacked_type    ua;
   fp_unpacked_type    ub;
   fp_class_type       cls_in;

   logic [23:0]        ma_ff;
   logic [23:0]        mb_ff;
   logic signed [10:0] exp_a_ff;
   fp_class_type       cls_a_ff;

   logic [47:0]        prod_ff;
   logic signed [10:0] exp_b_ff;
   fp_class_type       cls_b_ff;

   float_type          y_in;
   float_type          y_ff;

   always_comb begin
      ua = fp_unpack(a, 1'b1);
      ub = fp_unpack(b, 1'b1);
      cls_in.sign = ua.sign ^ ub.sign;
      cls_in.nan  = ua.nan | ub.nan | (ua.inf & ub.zero) | (ua.zero & ub.inf);
      cls_in.inf  = !cls_in.nan & (ua.inf | ub.inf);
      cls_in.zero = !cls_in.nan & !cls_in.inf & (ua.zero | ub.zero);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff    <= ua.man;
         mb_ff    <= ub.man;
         exp_a_ff <= ua.exp + ub.exp - 11'sd127;
         cls_a_ff <= cls_in;
         prod_ff  <= ma_ff * mb_ff;
         exp_b_ff <= exp_a_ff;
         cls_b_ff <= cls_a_ff;
         y_ff     <= y_in;
      end
   end

   always_comb begin
      if (prod_ff[47]) begin
         y_in = fp_round(cls_b_ff.sign, exp_b_ff + 11'sd1, {prod_ff[47:22], |prod_ff[21:0]});
      end else begin
         y_in = fp_round(cls_b_ff.sign, exp_b_ff, {prod_ff[46:21], |prod_ff[20:0]});
      end
      y_in = fp_select(cls_b_ff, y_in);
   end

   assign y = y_ff;

endmodule

`default_nettype wire

FILE: rtl/rti_fadd.sv
//------------------------------------------------------------------------------
// rti_fadd
// Three-stage single-precision adder, round to nearest even:
// align, add with leading zero count, normalize and round.
//------------------------------------------------------------------------------
`default_nettype none

module rti_fadd (
   input  wire                 clock,
   input  wire                 en,
   input  rti_pkg::float_type  a,
   input  rti_pkg::float_type  b,
   output rti_pkg::float_type  y
);
   import rti_pkg::*;

   fp_unpacked_type    ua;
   fp_unpacked_type    ub;
   fp_unpacked_type    big;
   fp_unpacked_type    sml;
   logic signed [10:0] dexp;
   logic [4:0]         sh;
   logic [26:0]        ms;
   logic [26:0]        msml_in;
   fp_class_type       cls_in;

   logic               sign_a_ff;
   logic               sub_a_ff;
   logic               zsign_a_ff;
   logic signed [10:0] exp_a_ff;
   logic [26:0]        mbig_ff;
   logic [26:0]        msml_ff;
   fp_class_type       cls_a_ff;

   logic [27:0]        sum_in;
   logic               sign_b_ff;
   logic               zsign_b_ff;
   logic signed [10:0] exp_b_ff;
   logic [27:0]        sum_ff;
   logic [4:0]         lz_ff;
   fp_class_type       cls_b_ff;

   logic [4:0]         lsh;
   float_type          y_in;
   float_type          y_ff;

   always_comb begin
      ua = fp_unpack(a, 1'b0);
      ub = fp_unpack(b, 1'b0);
      if (b[30:0] > a[30:0]) begin
         big = ub;
         sml = ua;
      end else begin
         big = ua;
         sml = ub;
      end
      dexp    = big.exp - sml.exp;
      sh      = (dexp > 11'sd27) ? 5'd27 : dexp[4:0];
      ms      = {sml.man, 3'b000};
      msml_in = (ms >> sh) | {26'd0, |(ms & ((27'd1 << sh) - 27'd1))};
      cls_in.nan  = ua.nan | ub.nan | (ua.inf & ub.inf & (ua.sign ^ ub.sign));
      cls_in.inf  = !cls_in.nan & (ua.inf | ub.inf);
      cls_in.sign = ua.inf ? ua.sign : ub.sign;
      cls_in.zero = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sign_a_ff  <= big.sign;
         sub_a_ff   <= ua.sign ^ ub.sign;
         zsign_a_ff <= ua.sign & ub.sign;
         exp_a_ff   <= big.exp;
         mbig_ff    <= {big.man, 3'b000};
         msml_ff    <= msml_in;
         cls_a_ff   <= cls_in;
         sign_b_ff  <= sign_a_ff;
         zsign_b_ff <= zsign_a_ff;
         exp_b_ff   <= exp_a_ff;
         sum_ff     <= sum_in;
         lz_ff      <= lzc28(sum_in);
         cls_b_ff   <= cls_a_ff;
         y_ff       <= y_in;
      end
   end

   always_comb begin
      if (sub_a_ff) begin
         sum_in = {1'b0, mbig_ff} - {1'b0, msml_ff};
      end else begin
         sum_in = {1'b0, mbig_ff} + {1'b0, msml_ff};
      end
   end

   always_comb begin
      lsh = lz_ff - 5'd1;
      if (sum_ff == 28'd0) begin
         y_in = {zsign_b_ff, 31'd0};
      end else if (sum_ff[27]) begin
         y_in = fp_round(sign_b_ff, exp_b_ff + 11'sd1, {sum_ff[27:2], |sum_ff[1:0]});
      end else begin
         y_in = fp_round(sign_b_ff, exp_b_ff - $signed({6'd0, lsh}), sum_ff[26:0] << lsh);
      end
      y_in = fp_select(cls_b_ff, y_in);
   end

   assign y = y_ff;

endmodule

`default_nettype wire

FILE: rtl/rti_fdiv.sv
//------------------------------------------------------------------------------
// rti_fdiv
// Pipelined single-precision divider, round to nearest even: one restoring
// quotient bit per stage between an unpack stage and a rounding stage.
//------------------------------------------------------------------------------
`default_nettype none

module rti_fdiv (
   input  wire                 clock,
   input  wire                 en,
   input  rti_pkg::float_type  a,
   input  rti_pkg::float_type  b,
   output rti_pkg::float_type  y
);
   import rti_pkg::*;

   fp_unpacked_type    ua;
   fp_unpacked_type    ub;
   logic               lt;
   fp_class_type       cls_in;

   logic [24:0]          rem_ff [0:QUO_BITS];
   logic [QUO_BITS-1:0]  quo_ff [0:QUO_BITS];
   logic [23:0]          den_ff [0:QUO_BITS];
   logic signed [10:0]   exp_ff [0:QUO_BITS];
   fp_class_type         cls_ff [0:QUO_BITS];

   logic                 ge     [0:QUO_BITS-1];
   logic [24:0]          rnext  [0:QUO_BITS-1];

   float_type            y_in;
   float_type            y_ff;

   always_comb begin
      ua = fp_unpack(a, 1'b1);
      ub = fp_unpack(b, 1'b1);
      lt = ua.man < ub.man;
      cls_in.sign = ua.sign ^ ub.sign;
      cls_in.nan  = ua.nan | ub.nan | (ua.zero & ub.zero) | (ua.inf & ub.inf);
      cls_in.inf  = !cls_in.nan & (ua.inf | ub.zero);
      cls_in.zero = !cls_in.nan & !cls_in.inf & (ua.zero | ub.inf);
   end

   always_comb begin
      for (int j = 0; j < QUO_BITS; j++) begin
         ge[j]    = rem_ff[j] >= {1'b0, den_ff[j]};
         rnext[j] = ge[j] ? (rem_ff[j] - {1'b0, den_ff[j]}) : rem_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= lt ? {ua.man, 1'b0} : {1'b0, ua.man};
         quo_ff[0] <= '0;
         den_ff[0] <= ub.man;
         exp_ff[0] <= ua.exp - ub.exp + 11'sd127 - (lt ? 11'sd1 : 11'sd0);
         cls_ff[0] <= cls_in;
         for (int j = 0; j < QUO_BITS; j++) begin
            rem_ff[j+1] <= {rnext[j][23:0], 1'b0};
            quo_ff[j+1] <= {quo_ff[j][QUO_BITS-2:0], ge[j]};
            den_ff[j+1] <= den_ff[j];
            exp_ff[j+1] <= exp_ff[j];
            cls_ff[j+1] <= cls_ff[j];
         end
         y_ff <= y_in;
      end
   end

   always_comb begin
      y_in = fp_round(cls_ff[QUO_BITS].sign, exp_ff[QUO_BITS],
                      {quo_ff[QUO_BITS], |rem_ff[QUO_BITS]});
      y_in = fp_select(cls_ff[QUO_BITS], y_in);
   end

   assign y = y_ff;

endmodule

`default_nettype wire

FILE: rtl/ray_triangle_intersect.sv
//------------------------------------------------------------------------------
// ray_triangle_intersect
// Single-precision ray/triangle hit test against one triangle held in
// configuration registers.
//
// Rays enter on the req_ stream (origin x,y,z then direction x,y,z, float
// bits). Each ray gives one item on the rsp_ stream: hit in rsp_tuser and the
// distance along the direction in rsp_tdata (zero when there is no hit).
// The user must write the triangle vertices through the csr_ port only while
// the stream is idle; the block does not enforce this. Register index 0..5
// selects A xy, A z, B xy, B z, C xy, C z. From acceptance to rsp_tvalid a ray
// passes edge subtraction, two cross products and four dot products in float
// units, the division by the determinant one quotient bit per stage, and the
// output register. One ray is accepted every cycle while the pipeline is not held.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_tready drops; nothing is lost or repeated.
// Reset clears the vertex registers to zero and empties the pipeline.
//------------------------------------------------------------------------------
`default_nettype none

module ray_triangle_intersect (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [191:0] req_tdata,    // origin_x, origin_y, origin_z, direction_x, _y, _z
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [31:0]  rsp_tdata,    // distance
   output logic [0:0]   rsp_tuser,    // hit
   input  wire          csr_we,
   input  wire  [2:0]   csr_addr,
   input  wire  [63:0]  csr_wdata
);
   import rti_pkg::*;

   localparam int T_SUB   = ADD_LAT;
   localparam int T_CROSS = T_SUB + MUL_LAT + ADD_LAT;
   localparam int T_DOT   = T_CROSS + MUL_LAT + 2 * ADD_LAT;
   localparam int T_UV    = T_DOT + ADD_LAT;
   localparam int T_END   = T_DOT + DIV_LAT;
   localparam int D_EDGE  = T_CROSS - T_SUB;
   localparam int D_REJ0  = T_END - T_DOT;
   localparam int D_REJ1  = T_END - T_UV;

   logic [63:0] a_xy_ff;
   logic [31:0] a_z_ff;
   logic [63:0] b_xy_ff;
   logic [31:0] b_z_ff;
   logic [63:0] c_xy_ff;
   logic [31:0] c_z_ff;

   logic        adv;

   float_type   va   [0:2];
   float_type   vb   [0:2];
   float_type   vc   [0:2];
   float_type   org  [0:2];
   float_type   dir  [0:2];
   float_type   ab3  [0:2];
   float_type   ac3  [0:2];
   float_type   ao3  [0:2];
   float_type   pm0  [0:2];
   float_type   pm1  [0:2];
   float_type   qm0  [0:2];
   float_type   qm1  [0:2];
   float_type   p9   [0:2];
   float_type   q9   [0:2];

   float_type   dly_dir_ff [1:T_CROSS][0:2];
   float_type   dly_ab_ff  [1:D_EDGE][0:2];
   float_type   dly_ac_ff  [1:D_EDGE][0:2];
   float_type   dly_ao_ff  [1:D_EDGE][0:2];

   float_type   dot_a   [0:3][0:2];
   float_type   dot_b   [0:3][0:2];
   float_type   dot_m   [0:3][0:2];
   float_type   dot_s   [0:3];
   float_type   dot_r   [0:3];
   float_type   dly_m2_ff [0:3][1:ADD_LAT];

   logic        neg;
   float_type   det_pos;
   float_type   u_val;
   float_type   v_val;
   float_type   num_val;
   logic        rej0_in;
   float_type   uv;
   float_type   quo;
   logic        rej1_in;

   float_type   dly_det_ff  [1:ADD_LAT];
   float_type   dly_v_ff    [1:ADD_LAT];
   logic        dly_rej0_ff [1:D_REJ0];
   logic        dly_rej1_ff [1:D_REJ1];
   logic        vld_ff      [1:T_END];

   logic        hit_in;
   logic        rsp_valid_ff;
   logic        rsp_hit_ff;
   float_type   rsp_dist_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_xy_ff <= '0;
         a_z_ff  <= '0;
         b_xy_ff <= '0;
         b_z_ff  <= '0;
         c_xy_ff <= '0;
         c_z_ff  <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_A_XY: begin
               a_xy_ff <= csr_wdata;
            end
            CSR_A_Z: begin
               a_z_ff <= csr_wdata[31:0];
            end
            CSR_B_XY: begin
               b_xy_ff <= csr_wdata;
            end
            CSR_B_Z: begin
               b_z_ff <= csr_wdata[31:0];
            end
            CSR_C_XY: begin
               c_xy_ff <= csr_wdata;
            end
            CSR_C_Z: begin
               c_z_ff <= csr_wdata[31:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      va[0] = a_xy_ff[63:32];
      va[1] = a_xy_ff[31:0];
      va[2] = a_z_ff;
      vb[0] = b_xy_ff[63:32];
      vb[1] = b_xy_ff[31:0];
      vb[2] = b_z_ff;
      vc[0] = c_xy_ff[63:32];
      vc[1] = c_xy_ff[31:0];
      vc[2] = c_z_ff;
      for (int i = 0; i < 3; i++) begin
         org[i] = req_tdata[32*i +: 32];
         dir[i] = req_tdata[96 + 32*i +: 32];
      end
   end

   // edges, origin offset and both cross products
   for (genvar i = 0; i < 3; i++) begin : g_vec
      rti_fadd u_sub_ab (.clock(clock), .en(adv), .a(vb[i]),
                        .b({~va[i][31], va[i][30:0]}), .y(ab3[i]));
      rti_fadd u_sub_ac (.clock(clock), .en(adv), .a(vc[i]),
                        .b({~va[i][31], va[i][30:0]}), .y(ac3[i]));
      rti_fadd u_sub_ao (.clock(clock), .en(adv), .a(org[i]),
                        .b({~va[i][31], va[i][30:0]}), .y(ao3[i]));

      rti_fmul u_pm0 (.clock(clock), .en(adv), .a(dly_dir_ff[T_SUB][(i+1)%3]),
                      .b(ac3[(i+2)%3]), .y(pm0[i]));
      rti_fmul u_pm1 (.clock(clock), .en(adv), .a(ac3[(i+1)%3]),
                      .b(dly_dir_ff[T_SUB][(i+2)%3]), .y(pm1[i]));
      rti_fadd u_p   (.clock(clock), .en(adv), .a(pm0[i]),
                      .b({~pm1[i][31], pm1[i][30:0]}), .y(p9[i]));

      rti_fmul u_qm0 (.clock(clock), .en(adv), .a(ao3[(i+1)%3]),
                      .b(ab3[(i+2)%3]), .y(qm0[i]));
      rti_fmul u_qm1 (.clock(clock), .en(adv), .a(ab3[(i+1)%3]),
                      .b(ao3[(i+2)%3]), .y(qm1[i]));
      rti_fadd u_q   (.clock(clock), .en(adv), .a(qm0[i]),
                      .b({~qm1[i][31], qm1[i][30:0]}), .y(q9[i]));
   end

   // dot products: det, u, v and the distance numerator
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dot_a[0][i] = dly_ab_ff[D_EDGE][i];
         dot_b[0][i] = p9[i];
         dot_a[1][i] = dly_ao_ff[D_EDGE][i];
         dot_b[1][i] = p9[i];
         dot_a[2][i] = dly_dir_ff[T_CROSS][i];
         dot_b[2][i] = q9[i];
         dot_a[3][i] = dly_ac_ff[D_EDGE][i];
         dot_b[3][i] = q9[i];
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_dot
      for (genvar i = 0; i < 3; i++) begin : g_term
         rti_fmul u_mul (.clock(clock), .en(adv), .a(dot_a[k][i]), .b(dot_b[k][i]),
                         .y(dot_m[k][i]));
      end
      rti_fadd u_add01 (.clock(clock), .en(adv), .a(dot_m[k][0]), .b(dot_m[k][1]),
                        .y(dot_s[k]));
      rti_fadd u_add2  (.clock(clock), .en(adv), .a(dot_s[k]), .b(dly_m2_ff[k][ADD_LAT]),
                        .y(dot_r[k]));
   end

   // orientation fix-up and the first range tests
   always_comb begin
      neg     = fp_lt0(dot_r[0]);
      det_pos = neg ? {1'b0, dot_r[0][30:0]} : dot_r[0];
      u_val   = {dot_r[1][31] ^ neg, dot_r[1][30:0]};
      v_val   = {dot_r[2][31] ^ neg, dot_r[2][30:0]};
      num_val = {dot_r[3][31] ^ neg, dot_r[3][30:0]};
      rej0_in = (dot_r[0][30:0] < NEAR_PARALLEL[30:0]) || fp_lt0(u_val) ||
                fp_gt(u_val, det_pos);
   end

   rti_fadd u_uv  (.clock(clock), .en(adv), .a(u_val), .b(v_val), .y(uv));
   rti_fdiv u_div (.clock(clock), .en(adv), .a(num_val), .b(det_pos), .y(quo));

   assign rej1_in = fp_lt0(dly_v_ff[ADD_LAT]) || fp_gt(uv, dly_det_ff[ADD_LAT]);

   // delay lines
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dly_dir_ff[1][i] <= dir[i];
            for (int s = 2; s <= T_CROSS; s++) begin
               dly_dir_ff[s][i] <= dly_dir_ff[s-1][i];
            end
            dly_ab_ff[1][i] <= ab3[i];
            dly_ac_ff[1][i] <= ac3[i];
            dly_ao_ff[1][i] <= ao3[i];
            for (int s = 2; s <= D_EDGE; s++) begin
               dly_ab_ff[s][i] <= dly_ab_ff[s-1][i];
               dly_ac_ff[s][i] <= dly_ac_ff[s-1][i];
               dly_ao_ff[s][i] <= dly_ao_ff[s-1][i];
            end
         end
         for (int k = 0; k < 4; k++) begin
            dly_m2_ff[k][1] <= dot_m[k][2];
            for (int s = 2; s <= ADD_LAT; s++) begin
               dly_m2_ff[k][s] <= dly_m2_ff[k][s-1];
            end
         end
         dly_det_ff[1] <= det_pos;
         dly_v_ff[1]   <= v_val;
         for (int s = 2; s <= ADD_LAT; s++) begin
            dly_det_ff[s] <= dly_det_ff[s-1];
            dly_v_ff[s]   <= dly_v_ff[s-1];
         end
         dly_rej0_ff[1] <= rej0_in;
         for (int s = 2; s <= D_REJ0; s++) begin
            dly_rej0_ff[s] <= dly_rej0_ff[s-1];
         end
         dly_rej1_ff[1] <= rej1_in;
         for (int s = 2; s <= D_REJ1; s++) begin
            dly_rej1_ff[s] <= dly_rej1_ff[s-1];
         end
      end
   end

   // item valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= T_END; s++) begin
            vld_ff[s] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[1] <= req_tvalid;
         for (int s = 2; s <= T_END; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         rsp_valid_ff <= vld_ff[T_END];
      end
   end

   assign hit_in = !dly_rej0_ff[D_REJ0] && !dly_rej1_ff[D_REJ1] && fp_gt0(quo);

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff  <= hit_in;
         rsp_dist_ff <= hit_in ? quo : 32'd0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_dist_ff;
   assign rsp_tuser[0] = rsp_hit_ff;

endmodule

`default_nettype wire

FILE: dv/tb.sv
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the ray/triangle hit test. Triangles are loaded
// through the csr port while the stream is idle. Rays go in on the req
// stream and every result on the rsp stream is checked against a bit-exact
// single-precision model of the hit test. A short directed table covers
// hits, back faces, near-parallel rays, triangle edges, zero distance and
// NaN/infinity/subnormal operands. Random rays follow, mostly aimed at the
// triangle, under three sender/receiver idle mixes.
//------------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rti_pkg::*;

   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      float_type x;
      float_type y;
      float_type z;
   } vec3_type;

   typedef struct packed {
      logic      hit;
      float_type distance;
   } hit_type;

   typedef struct {
      vec3_type org;
      vec3_type dir;
      logic     typed;
      hit_type  want;
   } ray_row_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [191:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [31:0]   rsp_tdata;
   logic [0:0]    rsp_tuser;
   logic          csr_we;
   logic [2:0]    csr_addr;
   logic [63:0]   csr_wdata;

   logic [63:0]   vertex_regs [6];
   hit_type       hit_q [$];
   int            mismatches;
   int            snd_idle_pct;
   int            rcv_idle_pct;

   ray_triangle_intersect i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("ray_triangle_intersect regression: fail");
      $finish;
   end

   // single-precision arithmetic through double: exact or innocuously rounded
   function automatic real pow2(input int k);
      logic [10:0] e;
      e = 11'(k + 1023);
      return $bitstoreal({1'b0, e, 52'd0});
   endfunction

   function automatic real to_real(input float_type f);
      real v;
      int  e;
      e = int'(f[30:23]);
      if (e == 255) begin
         v = (f[22:0] == 23'd0) ? $bitstoreal(64'h7FF0000000000000)
                                : $bitstoreal(64'h7FF8000000000000);
      end else begin
         v = real'(int'({e != 0, f[22:0]})) * pow2(((e == 0) ? 1 : e) - 150);
      end
      return f[31] ? -v : v;
   endfunction

   function automatic float_type to_float(input real x);
      logic [63:0] b;
      logic [63:0] sig;
      logic [63:0] mant;
      logic [63:0] rem;
      logic [63:0] half;
      int          ex;
      int          sh;
      float_type   r;
      b = $realtobits(x);
      if (b[62:52] == 11'h7FF) begin
         r = (b[51:0] != 52'd0) ? QNAN : {b[63], 8'hFF, 23'd0};
      end else if (b[62:52] == 11'd0) begin
         r = {b[63], 31'd0};
      end else begin
         ex  = int'(b[62:52]) - 1023;
         sig = {11'd0, 1'b1, b[51:0]};
         sh  = (ex >= -126) ? 29 : 29 + (-126 - ex);
         if (sh > 63) begin
            sh = 63;
         end
         mant = sig >> sh;
         rem  = sig & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && mant[0])) begin
            mant = mant + 64'd1;
         end
         if (ex >= -126) begin
            if (mant[24]) begin
               mant = mant >> 1;
               ex   = ex + 1;
            end
            r = (ex > 127) ? {b[63], 8'hFF, 23'd0} : {b[63], 8'(ex + 127), mant[22:0]};
         end else begin
            r = {b[63], 7'd0, mant[23], mant[22:0]};
         end
      end
      return r;
   endfunction

   function automatic float_type fmul(input float_type a, input float_type b);
      return to_float(to_real(a) * to_real(b));
   endfunction

   function automatic float_type fadd(input float_type a, input float_type b);
      return to_float(to_real(a) + to_real(b));
   endfunction

   function automatic float_type fsub(input float_type a, input float_type b);
      return to_float(to_real(a) - to_real(b));
   endfunction

   function automatic vec3_type vsub(input vec3_type a, input vec3_type b);
      return '{fsub(a.x, b.x), fsub(a.y, b.y), fsub(a.z, b.z)};
   endfunction

   function automatic vec3_type vcross(input vec3_type a, input vec3_type b);
      return '{fsub(fmul(a.y, b.z), fmul(b.y, a.z)),
               fsub(fmul(a.z, b.x), fmul(b.z, a.x)),
               fsub(fmul(a.x, b.y), fmul(b.x, a.y))};
   endfunction

   function automatic float_type vdot(input vec3_type a, input vec3_type b);
      return fadd(fadd(fmul(a.x, b.x), fmul(a.y, b.y)), fmul(a.z, b.z));
   endfunction

   function automatic vec3_type vertex(input int n);
      return '{vertex_regs[2*n][63:32], vertex_regs[2*n][31:0], vertex_regs[2*n+1][31:0]};
   endfunction

   function automatic hit_type trace_ray(input vec3_type org, input vec3_type dir);
      vec3_type  ab;
      vec3_type  ac;
      vec3_type  p;
      vec3_type  ao;
      vec3_type  q;
      float_type det;
      float_type u;
      float_type v;
      float_type t;
      real       rdet;
      hit_type   res;
      res  = '0;
      ab   = vsub(vertex(1), vertex(0));
      ac   = vsub(vertex(2), vertex(0));
      p    = vcross(dir, ac);
      det  = vdot(ab, p);
      rdet = to_real(det);
      if (((rdet < 0.0) ? -rdet : rdet) < to_real(NEAR_PARALLEL)) begin
         return res;
      end
      ao = vsub(org, vertex(0));
      if (rdet < 0.0) begin
         ao.x[31] = ~ao.x[31];
         ao.y[31] = ~ao.y[31];
         ao.z[31] = ~ao.z[31];
         det[31]  = ~det[31];
      end
      u = vdot(ao, p);
      if (to_real(u) < 0.0 || to_real(u) > to_real(det)) begin
         return res;
      end
      q = vcross(ao, ab);
      v = vdot(dir, q);
      if (to_real(v) < 0.0 || to_real(fadd(u, v)) > to_real(det)) begin
         return res;
      end
      t = to_float(to_real(vdot(ac, q)) / to_real(det));
      if (to_real(t) > 0.0) begin
         res.hit      = 1'b1;
         res.distance = t;
      end
      return res;
   endfunction

   function automatic float_type pick_float();
      float_type f;
      case ($urandom_range(0, 9))
         7: f = $urandom;
         8: begin
            case ($urandom_range(0, 7))
               0: f = 32'h00000000;
               1: f = 32'h80000000;
               2: f = 32'h7F800000;
               3: f = 32'hFF800000;
               4: f = QNAN;
               5: f = 32'h7F7FFFFF;
               6: f = 32'h00000001;
               default: f = NEAR_PARALLEL;
            endcase
         end
         default: f = to_float(real'($urandom_range(0, 64)) / 8.0 - 4.0);
      endcase
      return f;
   endfunction

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx <= CSR_C_Z) begin
         vertex_regs[idx] = idx[0] ? {32'd0, val[31:0]} : val;
      end
   endtask

   task automatic load_triangle(input vec3_type a, input vec3_type b, input vec3_type c);
      write_csr(CSR_A_XY, {a.x, a.y});
      write_csr(CSR_A_Z, {32'(($urandom)), a.z});
      write_csr(CSR_B_XY, {b.x, b.y});
      write_csr(CSR_B_Z, {32'(($urandom)), b.z});
      write_csr(CSR_C_XY, {c.x, c.y});
      write_csr(CSR_C_Z, {32'(($urandom)), c.z});
      write_csr(CSR_UNUSED, {$urandom, $urandom});
   endtask

   task automatic wait_drained();
      while (hit_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_ray(input vec3_type org, input vec3_type dir,
                           input logic typed, input hit_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {dir.z, dir.y, dir.x, org.z, org.y, org.x};
      do begin
         @(posedge clock);
      end while (!req_tready);
      hit_q.push_back(typed ? want : trace_ray(org, dir));
   endtask

   task automatic random_rays(input int count);
      vec3_type org;
      vec3_type dir;
      vec3_type v0;
      vec3_type v1;
      vec3_type v2;
      real      s;
      real      r;
      v0 = vertex(0);
      v1 = vertex(1);
      v2 = vertex(2);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 80) begin
            s   = real'($urandom_range(0, 100)) / 100.0;
            r   = real'($urandom_range(0, 100)) / 100.0 * (1.0 - s);
            org = '{pick_float(), pick_float(), pick_float()};
            if ($urandom_range(0, 3) != 0) begin
               org = '{to_float(real'($urandom_range(0, 40)) / 4.0 - 5.0),
                       to_float(real'($urandom_range(0, 40)) / 4.0 - 5.0),
                       to_float(real'($urandom_range(0, 40)) / 4.0 - 5.0)};
            end
            dir.x = to_float(to_real(v0.x) + s * (to_real(v1.x) - to_real(v0.x)) +
                    r * (to_real(v2.x) - to_real(v0.x)) - to_real(org.x));
            dir.y = to_float(to_real(v0.y) + s * (to_real(v1.y) - to_real(v0.y)) +
                    r * (to_real(v2.y) - to_real(v0.y)) - to_real(org.y));
            dir.z = to_float(to_real(v0.z) + s * (to_real(v1.z) - to_real(v0.z)) +
                    r * (to_real(v2.z) - to_real(v0.z)) - to_real(org.z));
         end else begin
            org = '{pick_float(), pick_float(), $urandom};
            dir = '{$urandom, pick_float(), pick_float()};
         end
         send_ray(org, dir, 1'b0, '0);
         if (n == count / 2 && $urandom_range(0, 1) == 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            wait_drained();
         end
      end
      @(negedge clock);
      req_tvalid = 1'b0;
      wait_drained();
   endtask

   task automatic random_triangle();
      load_triangle('{pick_float(), pick_float(), pick_float()},
                    '{pick_float(), pick_float(), pick_float()},
                    '{pick_float(), pick_float(), pick_float()});
   endtask

   always @(negedge clock) begin
      rsp_tready = reset ? 1'b0 : ($urandom_range(0, 99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin
      hit_type got;
      hit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser[0], rsp_tdata};
         if (hit_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected item: hit %0b distance %h", got.hit, got.distance);
            end
         end else begin
            want = hit_q.pop_front();
            if (got.hit !== want.hit || got.distance !== want.distance) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: hit %0b/%0b distance %h/%h (expected/actual)",
                           want.hit, got.hit, want.distance, got.distance);
               end
            end
         end
      end
   end

   ray_row_type rows [] = '{
      '{'{32'h3E800000, 32'h3E800000, 32'h3F800000}, '{32'h0, 32'h0, 32'hBF800000},
        1'b1, '{1'b1, 32'h3F800000}},
      '{'{32'h3E800000, 32'h3E800000, 32'h3F800000}, '{32'h0, 32'h0, 32'h3F800000},
        1'b1, '0},
      '{'{32'h3E800000, 32'h3E800000, 32'h3F800000}, '{32'h3F800000, 32'h0, 32'h0},
        1'b1, '0},
      '{'{32'h0, 32'h0, 32'h3F800000}, '{32'h0, 32'h0, 32'hBF800000}, 1'b0, '0},
      '{'{32'h3F000000, 32'h3F000000, 32'h3F800000}, '{32'h0, 32'h0, 32'hBF800000},
        1'b0, '0},
      '{'{32'h3F800000, 32'h3F800000, 32'h3F800000}, '{32'h0, 32'h0, 32'hBF800000},
        1'b1, '0},
      '{'{32'h3E800000, 32'h3E800000, 32'h0}, '{32'h0, 32'h0, 32'hBF800000}, 1'b1, '0},
      '{'{32'h3E800000, 32'h3E800000, 32'h3F800000}, '{32'h0, 32'h0, 32'h7FC00000},
        1'b1, '0},
      '{'{32'h7F800000, 32'h3E800000, 32'h3F800000}, '{32'h0, 32'h0, 32'hBF800000},
        1'b0, '0},
      '{'{32'h3E800000, 32'h3E800000, 32'h3F800000}, '{32'h0, 32'h0, 32'hFF7FFFFF},
        1'b0, '0},
      '{'{32'h80000000, 32'h80000000, 32'h3F800000}, '{32'h80000000, 32'h80000000,
        32'hBF800000}, 1'b0, '0},
      '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, '{32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF}, 1'b1, '0},
      '{'{32'h00000001, 32'h3E800000, 32'h3F800000}, '{32'h0, 32'h0, 32'hBF800000},
        1'b0, '0},
      '{'{32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0}, 1'b1, '0},
      '{'{32'h0, 32'h0, 32'h3F800000}, '{32'h0, 32'h0, 32'h80000001}, 1'b1, '0}
   };

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      mismatches   = 0;
      snd_idle_pct = 19;
      rcv_idle_pct = 60;
      for (int i = 0; i < 6; i++) begin
         vertex_regs[i] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all vertices zero after reset
      send_ray(rows[0].org, rows[0].dir, 1'b1, '0);
      @(negedge clock);
      req_tvalid = 1'b0;
      wait_drained();

      load_triangle('{32'h0, 32'h0, 32'h0}, '{32'h3F800000, 32'h0, 32'h0},
                    '{32'h0, 32'h3F800000, 32'h0});
      foreach (rows[i]) begin
         send_ray(rows[i].org, rows[i].dir, rows[i].typed, rows[i].want);
      end
      @(negedge clock);
      req_tvalid = 1'b0;
      wait_drained();

      load_triangle('{32'h7F7FFFFF, 32'hFF7FFFFF, 32'h7F7FFFFF},
                    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
                    '{32'h00000001, 32'h80000001, 32'h0});
      random_rays(8);

      for (int mode = 0; mode < 3; mode++) begin
         snd_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 60 : 0;
         rcv_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 19 : 0;
         for (int k = 0; k < 3; k++) begin
            if (k == 0) begin
               load_triangle('{to_float(-1.0), to_float(-1.0), to_float(2.0)},
                             '{to_float(3.0), to_float(-1.0), to_float(2.5)},
                             '{to_float(0.0), to_float(4.0), to_float(1.5)});
            end else begin
               random_triangle();
            end
            random_rays(48);
         end
      end

      repeat (100) @(posedge clock);
      if (mismatches == 0 && hit_q.size() == 0) begin
         $display("ray_triangle_intersect regression: pass");
      end else begin
         $display("ray_triangle_intersect regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
